// ===== sv/point_in_triangle_barycentric_macros.svh =====
// Assertion macros for the point-in-triangle block.
`ifndef POINT_IN_TRIANGLE_BARYCENTRIC_MACROS_SVH
`define POINT_IN_TRIANGLE_BARYCENTRIC_MACROS_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define PTIB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication after a fixed number of cycles.
`define PTIB_ASSERT_LAT(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(n) (cons)) \
    else $error("latency assertion failed");

`endif

// ===== sv/ptib_pkg.sv =====
// Shared constants and types of the point-in-triangle block.
package ptib_pkg;
  localparam int COORD_BITS_DEF       = 20;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int TAG_BITS_DEF         = 20;
  localparam int QBITS                = 32;  // quotient bits, one per divider stage
  localparam int OUT_W                = 45;  // outside measure width
  localparam int FRONT_STAGES         = 6;
  localparam logic [QBITS-1:0] LIMIT  = 32'h8000_0000;

  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;
endpackage

// ===== sv/ptib_front.sv =====
// Edge products, weight sum, outside measure and divider setup (six stages).
module ptib_front #(
  parameter int COORD_BITS       = ptib_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = ptib_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int TAG_BITS         = ptib_pkg::TAG_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW,
  localparam int WW = PW + 1,
  localparam int SW = WW + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [TAG_BITS-1:0]          tag_i,
  input  logic signed [COORD_BITS-1:0] vx_i [3],
  input  logic signed [COORD_BITS-1:0] vy_i [3],
  input  logic signed [COORD_BITS-1:0] qx_i,
  input  logic signed [COORD_BITS-1:0] qy_i,
  output ptib_pkg::ctl_t               ctl_o,
  output logic [TAG_BITS-1:0]          tag_o,
  output logic [ptib_pkg::OUT_W-1:0]   outside_o,
  output logic [SW-1:0]                den_o,
  output logic [SW-1:0]                rem_o [3],
  output logic [ptib_pkg::QBITS-1:0]   low_o [3],
  output logic                         sat_o [3],
  output logic                         neg_o [3]
);
  localparam int XW = WW + ptib_pkg::QBITS;
  localparam int NS = ptib_pkg::FRONT_STAGES;

  logic                v_q   [NS];
  logic [TAG_BITS-1:0] tag_q [NS];

  logic signed [DW-1:0] dx_q [3], dy_q [3];
  logic signed [PW-1:0] pa_q [3], pb_q [3];
  logic signed [WW-1:0] w_q  [3];
  logic signed [SW-1:0] sum4_q;
  logic        [WW-1:0] m4_q [3];
  logic                 wneg4_q [3];
  logic [ptib_pkg::OUT_W-1:0] out5_q;
  logic [SW-1:0]        d5_q;
  logic [WW-1:0]        n5_q [3];
  logic                 neg5_q [3];
  logic                 degen5_q;
  logic                 degen6_q;
  logic [ptib_pkg::OUT_W-1:0] out6_q;
  logic [SW-1:0]        d6_q;
  logic [SW-1:0]        rem6_q [3];
  logic [ptib_pkg::QBITS-1:0] low6_q [3];
  logic                 sat6_q [3], neg6_q [3];

  logic [WW-1:0] m_d [3];
  logic [SW-1:0] d_d;
  logic [XW-1:0] nx_d [3];
  logic [WW-1:0] hi_d [3];

  // valid bits and tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NS; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int s = 1; s < NS; s++) tag_q[s] <= tag_q[s-1];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_d[i]  = w_q[i][WW-1] ? -w_q[i] : w_q[i];
      nx_d[i] = XW'(n5_q[i]) << WEIGHT_FRAC_BITS;
      hi_d[i] = nx_d[i][XW-1:ptib_pkg::QBITS];
    end
    d_d = sum4_q[SW-1] ? -sum4_q : sum4_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      // stage 1: offsets of the query from each vertex
      dx_q[i] <= DW'(qx_i) - DW'(vx_i[i]);
      dy_q[i] <= DW'(qy_i) - DW'(vy_i[i]);
      // stage 3: edge functions
      w_q[i]  <= WW'(pa_q[i]) - WW'(pb_q[i]);
      // stage 4: magnitudes
      m4_q[i]    <= m_d[i];
      wneg4_q[i] <= w_q[i][WW-1];
      // stage 5
      n5_q[i]   <= m4_q[i];
      neg5_q[i] <= wneg4_q[i] ^ sum4_q[SW-1];
      // stage 6: integer-part overflow check and first remainder
      sat6_q[i] <= SW'(hi_d[i]) >= d5_q;
      rem6_q[i] <= SW'(hi_d[i]);
      low6_q[i] <= nx_d[i][ptib_pkg::QBITS-1:0];
      neg6_q[i] <= neg5_q[i];
    end
    // stage 2: cross products
    pa_q[0] <= dy_q[2] * dx_q[1];
    pb_q[0] <= dx_q[2] * dy_q[1];
    pa_q[1] <= dy_q[0] * dx_q[2];
    pb_q[1] <= dx_q[0] * dy_q[2];
    pa_q[2] <= dy_q[1] * dx_q[0];
    pb_q[2] <= dx_q[1] * dy_q[0];
    sum4_q   <= SW'(w_q[0]) + SW'(w_q[1]) + SW'(w_q[2]);
    out5_q   <= ptib_pkg::OUT_W'(SW'(m4_q[0]) + SW'(m4_q[1]) + SW'(m4_q[2])
                - $unsigned(sum4_q));
    d5_q     <= d_d;
    degen5_q <= (sum4_q == '0);
    out6_q   <= out5_q;
    d6_q     <= d5_q;
    degen6_q <= degen5_q;
  end

  assign ctl_o     = '{valid: v_q[NS-1], degen: degen6_q};
  assign tag_o     = tag_q[NS-1];
  assign outside_o = out6_q;
  assign den_o     = d6_q;
  assign rem_o     = rem6_q;
  assign low_o     = low6_q;
  assign sat_o     = sat6_q;
  assign neg_o     = neg6_q;
endmodule

// ===== sv/ptib_div.sv =====
// Restoring divider, one quotient bit per pipeline stage.
module ptib_div #(
  parameter int SW = 44
) (
  input  logic                       clk_i,
  input  logic [SW-1:0]              rem_i,
  input  logic [ptib_pkg::QBITS-1:0] low_i,
  input  logic [SW-1:0]              den_i,
  input  logic                       sat_i,
  input  logic                       neg_i,
  output logic [ptib_pkg::QBITS-1:0] quo_o,
  output logic                       sat_o,
  output logic                       neg_o
);
  localparam int QB = ptib_pkg::QBITS;

  // lq holds the dividend bits still to bring down (top) and quotient bits (bottom)
  logic [SW-1:0] rem_q [QB];
  logic [QB-1:0] lq_q  [QB];
  logic [SW-1:0] den_q [QB];
  logic          sat_q [QB];
  logic          neg_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [SW-1:0] rem_p, den_p;
    logic [QB-1:0] lq_p;
    logic          sat_p, neg_p;
    logic [SW:0]   t, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = rem_i;
      assign den_p = den_i;
      assign lq_p  = low_i;
      assign sat_p = sat_i;
      assign neg_p = neg_i;
    end else begin : g_rest
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign lq_p  = lq_q[k-1];
      assign sat_p = sat_q[k-1];
      assign neg_p = neg_q[k-1];
    end

    assign t    = {rem_p, lq_p[QB-1]};
    assign diff = t - {1'b0, den_p};
    assign ge   = t >= {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[SW-1:0] : t[SW-1:0];
      lq_q[k]  <= {lq_p[QB-2:0], ge};
      den_q[k] <= den_p;
      sat_q[k] <= sat_p;
      neg_q[k] <= neg_p;
    end
  end

  assign quo_o = lq_q[QB-1];
  assign sat_o = sat_q[QB-1];
  assign neg_o = neg_q[QB-1];
endmodule

// ===== sv/point_in_triangle_barycentric.sv =====
// Top level: point-in-triangle test with normalized barycentric weights.
//
//  channel   handshake          payload
//  -------   ---------------    ------------------------------------------------
//  command   start_i / busy_o   triangle_id_i, vertex{0,1,2}_{x,y}_i, query_{x,y}_i
//  result    done_o (strobe)    triangle_tag_o, outside_measure_o, weight{0,1,2}_o,
//                               degenerate_o
//
// One transfer is taken every cycle; busy_o is never raised.
// The pipeline has six arithmetic stages, 32 divider stages (one quotient bit each,
// three dividers side by side) and one output register.
// The result shows for one cycle on done_o; the receiver cannot stall, so the
// pipeline never holds.
// Reset clears only valid and control flags; data registers keep whatever they hold.
module point_in_triangle_barycentric #(
  parameter int COORD_BITS       = ptib_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = ptib_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int TAG_BITS         = ptib_pkg::TAG_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [TAG_BITS-1:0]          triangle_id_i,
  input  logic signed [COORD_BITS-1:0] vertex0_x_i,
  input  logic signed [COORD_BITS-1:0] vertex0_y_i,
  input  logic signed [COORD_BITS-1:0] vertex1_x_i,
  input  logic signed [COORD_BITS-1:0] vertex1_y_i,
  input  logic signed [COORD_BITS-1:0] vertex2_x_i,
  input  logic signed [COORD_BITS-1:0] vertex2_y_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  output logic                         done_o,
  output logic [TAG_BITS-1:0]          triangle_tag_o,
  output logic [ptib_pkg::OUT_W-1:0]   outside_measure_o,
  output logic signed [31:0]           weight0_o,
  output logic signed [31:0]           weight1_o,
  output logic signed [31:0]           weight2_o,
  output logic                         degenerate_o
);
  `include "point_in_triangle_barycentric_macros.svh"

  localparam int SW  = 2 * (COORD_BITS + 1) + 3;
  localparam int QB  = ptib_pkg::QBITS;
  localparam int LAT = ptib_pkg::FRONT_STAGES + QB + 1;

  logic signed [COORD_BITS-1:0] vx [3], vy [3];
  ptib_pkg::ctl_t             f_ctl;
  logic [TAG_BITS-1:0]        f_tag;
  logic [ptib_pkg::OUT_W-1:0] f_out;
  logic [SW-1:0]              f_den;
  logic [SW-1:0]              f_rem [3];
  logic [QB-1:0]              f_low [3];
  logic                       f_sat [3], f_neg [3];
  logic [QB-1:0]              d_quo [3];
  logic                       d_sat [3], d_neg [3];

  // side data riding alongside the dividers
  ptib_pkg::ctl_t             sc_ctl_q [QB];
  logic [TAG_BITS-1:0]        sc_tag_q [QB];
  logic [ptib_pkg::OUT_W-1:0] sc_out_q [QB];

  logic                       done_q;
  logic [TAG_BITS-1:0]        tag_q;
  logic [ptib_pkg::OUT_W-1:0] out_q;
  logic                       degen_q;
  logic [31:0]                w_q [3];
  logic [31:0]                w_d [3];
  logic [QB-1:0]              mag;

  assign busy_o = 1'b0;

  assign vx = '{vertex0_x_i, vertex1_x_i, vertex2_x_i};
  assign vy = '{vertex0_y_i, vertex1_y_i, vertex2_y_i};

  ptib_front #(
    .COORD_BITS      (COORD_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .TAG_BITS        (TAG_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .tag_i    (triangle_id_i),
    .vx_i     (vx),
    .vy_i     (vy),
    .qx_i     (query_x_i),
    .qy_i     (query_y_i),
    .ctl_o    (f_ctl),
    .tag_o    (f_tag),
    .outside_o(f_out),
    .den_o    (f_den),
    .rem_o    (f_rem),
    .low_o    (f_low),
    .sat_o    (f_sat),
    .neg_o    (f_neg)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    ptib_div #(.SW(SW)) u_div (
      .clk_i(clk_i),
      .rem_i(f_rem[i]),
      .low_i(f_low[i]),
      .den_i(f_den),
      .sat_i(f_sat[i]),
      .neg_i(f_neg[i]),
      .quo_o(d_quo[i]),
      .sat_o(d_sat[i]),
      .neg_o(d_neg[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QB; s++) sc_ctl_q[s] <= '0;
      done_q <= 1'b0;
    end else begin
      sc_ctl_q[0] <= f_ctl;
      for (int s = 1; s < QB; s++) sc_ctl_q[s] <= sc_ctl_q[s-1];
      done_q <= sc_ctl_q[QB-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_tag_q[0] <= f_tag;
    sc_out_q[0] <= f_out;
    for (int s = 1; s < QB; s++) begin
      sc_tag_q[s] <= sc_tag_q[s-1];
      sc_out_q[s] <= sc_out_q[s-1];
    end
  end

  // saturate the quotient magnitude, then apply the sign; a degenerate triangle gives zero weights
  always_comb begin
    mag = '0;
    for (int i = 0; i < 3; i++) begin
      mag = d_sat[i] ? ptib_pkg::LIMIT : d_quo[i];
      if (sc_ctl_q[QB-1].degen) begin
        w_d[i] = '0;
      end else if (d_neg[i]) begin
        w_d[i] = (mag > ptib_pkg::LIMIT) ? ptib_pkg::LIMIT : -mag;
      end else begin
        w_d[i] = (mag > ptib_pkg::LIMIT - 1'b1) ? ptib_pkg::LIMIT - 1'b1 : mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= sc_tag_q[QB-1];
    out_q   <= sc_out_q[QB-1];
    degen_q <= sc_ctl_q[QB-1].degen;
    w_q     <= w_d;
  end

  assign done_o            = done_q;
  assign triangle_tag_o    = tag_q;
  assign outside_measure_o = out_q;
  assign degenerate_o      = degen_q;
  assign weight0_o         = w_q[0];
  assign weight1_o         = w_q[1];
  assign weight2_o         = w_q[2];

  // every transfer in gives one result a fixed time later
  `PTIB_ASSERT_LAT(a_latency, start_i && !busy_o, LAT, done_o)
  // a degenerate triangle reports zero weights
  `PTIB_ASSERT_IMPL(a_degen_zero, done_o && degenerate_o,
                    weight0_o == 0 && weight1_o == 0 && weight2_o == 0)
  // a point inside a proper triangle has no negative weight
  `PTIB_ASSERT_IMPL(a_inside_pos, done_o && !degenerate_o && outside_measure_o == 0,
                    !weight0_o[31] && !weight1_o[31] && !weight2_o[31])
endmodule

// ===== tb/point_in_triangle_barycentric_tb.sv =====
// Self-checking testbench for the point-in-triangle barycentric block.
module point_in_triangle_barycentric_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = ptib_pkg::COORD_BITS_DEF;
  localparam int FRAC       = ptib_pkg::WEIGHT_FRAC_BITS_DEF;
  localparam int TW         = ptib_pkg::TAG_BITS_DEF;
  localparam int LATENCY    = 39;
  localparam int CYCLE_CAP  = 200000;
  localparam int CMAX       = (1 << (CW - 1)) - 1;
  localparam int CMIN       = -(1 << (CW - 1));

  typedef struct {
    logic [TW-1:0]        id;
    logic signed [CW-1:0] x0, y0, x1, y1, x2, y2, qx, qy;
  } tri_query_t;

  typedef struct {
    logic [TW-1:0]             tag;
    logic [ptib_pkg::OUT_W-1:0] outside;
    logic [31:0]               wt0, wt1, wt2;
    logic                      degen;
  } location_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [TW-1:0]         triangle_id_i = '0;
  logic signed [CW-1:0]  vertex0_x_i = '0, vertex0_y_i = '0;
  logic signed [CW-1:0]  vertex1_x_i = '0, vertex1_y_i = '0;
  logic signed [CW-1:0]  vertex2_x_i = '0, vertex2_y_i = '0;
  logic signed [CW-1:0]  query_x_i = '0, query_y_i = '0;
  logic                  done_o;
  logic [TW-1:0]         triangle_tag_o;
  logic [ptib_pkg::OUT_W-1:0] outside_measure_o;
  logic signed [31:0]    weight0_o, weight1_o, weight2_o;
  logic                  degenerate_o;

  location_t pending_locations[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        sent = 0;
  int        checked = 0;
  int        degen_seen = 0;
  int        inside_seen = 0;
  int        burst_left = 8;

  point_in_triangle_barycentric u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .triangle_id_i,
    .vertex0_x_i, .vertex0_y_i, .vertex1_x_i, .vertex1_y_i,
    .vertex2_x_i, .vertex2_y_i, .query_x_i, .query_y_i,
    .done_o, .triangle_tag_o, .outside_measure_o,
    .weight0_o, .weight1_o, .weight2_o, .degenerate_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Saturating signed quotient num/den in Q(31-FRAC).FRAC, truncated toward zero.
  function automatic logic [31:0] ratio_q(longint num, longint den);
    longint unsigned n, d, ip, r, frac, q, lim;
    bit neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    lim = 64'd1 << 31;
    ip = n / d;
    r = n % d;
    frac = 0;
    if (ip > (lim >> FRAC)) begin
      q = lim;
    end else begin
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= d) begin
          r = r - d;
          frac = frac | 1;
        end
      end
      q = (ip << FRAC) | frac;
    end
    if (neg) begin
      if (q > lim) q = lim;
      return 32'(-q);
    end
    if (q > lim - 1) q = lim - 1;
    return 32'(q);
  endfunction

  // Edge cross products, outside measure and normalized weights.
  function automatic location_t locate(tri_query_t t);
    location_t e;
    longint ex0, ey0, ex1, ey1, ex2, ey2, c0, c1, c2, total;
    longint unsigned mags;
    ex0 = longint'(t.qx) - longint'(t.x0);
    ey0 = longint'(t.qy) - longint'(t.y0);
    ex1 = longint'(t.qx) - longint'(t.x1);
    ey1 = longint'(t.qy) - longint'(t.y1);
    ex2 = longint'(t.qx) - longint'(t.x2);
    ey2 = longint'(t.qy) - longint'(t.y2);
    c0 = ey2 * ex1 - ex2 * ey1;
    c1 = ey0 * ex2 - ex0 * ey2;
    c2 = ey1 * ex0 - ex1 * ey0;
    total = c0 + c1 + c2;
    mags = ((c0 < 0) ? -c0 : c0) + ((c1 < 0) ? -c1 : c1) + ((c2 < 0) ? -c2 : c2);
    e.tag = t.id;
    e.outside = ptib_pkg::OUT_W'(mags - longint'(total));
    if (total == 0) begin
      e.wt0 = '0;
      e.wt1 = '0;
      e.wt2 = '0;
      e.degen = 1'b1;
    end else begin
      e.wt0 = ratio_q(c0, total);
      e.wt1 = ratio_q(c1, total);
      e.wt2 = ratio_q(c2, total);
      e.degen = 1'b0;
    end
    return e;
  endfunction

  // Present one command, hold it until the transfer, then idle per burst plan.
  task automatic send_query(tri_query_t t);
    start_i       <= 1'b1;
    triangle_id_i <= t.id;
    vertex0_x_i   <= t.x0;
    vertex0_y_i   <= t.y0;
    vertex1_x_i   <= t.x1;
    vertex1_y_i   <= t.y1;
    vertex2_x_i   <= t.x2;
    vertex2_y_i   <= t.y2;
    query_x_i     <= t.qx;
    query_y_i     <= t.qy;
    do @(posedge clk_i); while (busy_o);
    pending_locations.push_back(locate(t));
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      // Mostly short bursts, sometimes a long unbroken stream.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 12);
    end
  endtask

  // Result checker: every done_o strobe is a transfer that must match the oldest entry.
  always @(posedge clk_i) begin
    location_t e;
    if (rst_ni && done_o) begin
      if (pending_locations.size() == 0) begin
        $error("result with no pending command, tag %0h", triangle_tag_o);
        mismatches++;
      end else begin
        e = pending_locations.pop_front();
        checked++;
        if (e.degen) degen_seen++;
        if (e.outside == 0) inside_seen++;
        if (triangle_tag_o !== e.tag) begin
          $error("triangle_tag exp %0h got %0h", e.tag, triangle_tag_o);
          mismatches++;
        end
        if (outside_measure_o !== e.outside) begin
          $error("outside_measure exp %0d got %0d", e.outside, outside_measure_o);
          mismatches++;
        end
        if (weight0_o !== e.wt0) begin
          $error("weight0 exp %0h got %0h", e.wt0, weight0_o);
          mismatches++;
        end
        if (weight1_o !== e.wt1) begin
          $error("weight1 exp %0h got %0h", e.wt1, weight1_o);
          mismatches++;
        end
        if (weight2_o !== e.wt2) begin
          $error("weight2 exp %0h got %0h", e.wt2, weight2_o);
          mismatches++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate exp %0b got %0b", e.degen, degenerate_o);
          mismatches++;
        end
      end
    end
  end

  function automatic tri_query_t mk(int id, int x0, int y0, int x1, int y1,
                                    int x2, int y2, int qx, int qy);
    tri_query_t t;
    t.id = TW'(id);
    t.x0 = CW'(x0); t.y0 = CW'(y0);
    t.x1 = CW'(x1); t.y1 = CW'(y1);
    t.x2 = CW'(x2); t.y2 = CW'(y2);
    t.qx = CW'(qx); t.qy = CW'(qy);
    return t;
  endfunction

  // Fully random bits in every field.
  function automatic tri_query_t random_wide();
    return mk($urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Triangle with a query inside or on it, as a convex mix of the vertices.
  function automatic tri_query_t random_inside();
    int span, x0, y0, x1, y1, x2, y2, a, b;
    span = ($urandom_range(0, 3) == 0) ? (1 << 18) : $urandom_range(4, 4096);
    x0 = $urandom_range(0, 2 * span) - span;  y0 = $urandom_range(0, 2 * span) - span;
    x1 = $urandom_range(0, 2 * span) - span;  y1 = $urandom_range(0, 2 * span) - span;
    x2 = $urandom_range(0, 2 * span) - span;  y2 = $urandom_range(0, 2 * span) - span;
    a = $urandom_range(0, 256);
    b = $urandom_range(0, 256 - a);
    return mk($urandom, x0, y0, x1, y1, x2, y2,
              x0 + ((x1 - x0) * a + (x2 - x0) * b) / 256,
              y0 + ((y1 - y0) * a + (y2 - y0) * b) / 256);
  endfunction

  // Collinear vertices: zero weight sum.
  function automatic tri_query_t random_collinear();
    int bx, by, dx, dy, k1, k2;
    bx = $urandom_range(0, 2000) - 1000;  by = $urandom_range(0, 2000) - 1000;
    dx = $urandom_range(0, 200) - 100;    dy = $urandom_range(0, 200) - 100;
    k1 = $urandom_range(0, 200) - 100;    k2 = $urandom_range(0, 200) - 100;
    return mk($urandom, bx, by, bx + dx * k1, by + dy * k1, bx + dx * k2, by + dy * k2,
              $urandom, $urandom);
  endfunction

  // Sliver triangle with a far query: weights saturate.
  function automatic tri_query_t random_sliver();
    int bx, by;
    bx = $urandom_range(0, 2000) - 1000;
    by = $urandom_range(0, 2000) - 1000;
    return mk($urandom, bx, by, bx + 1, by, bx, by + 1,
              $urandom_range(0, 2 * CMAX) - CMAX, $urandom_range(0, 2 * CMAX) - CMAX);
  endfunction

  task automatic test_directed();
    send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));                          // all zero
    send_query(mk(32'hFFFFF, 0, 0, 16, 0, 0, 16, 4, 4));                 // inside, max tag
    send_query(mk(1, 0, 0, 16, 0, 0, 16, 40, 40));                       // outside
    send_query(mk(2, 0, 0, 16, 0, 0, 16, 0, 0));                         // query on a vertex
    send_query(mk(3, 0, 0, 16, 0, 0, 16, 8, 0));                         // query on an edge
    send_query(mk(4, 0, 0, 0, 16, 16, 0, 4, 4));                         // clockwise winding
    send_query(mk(5, 1, 1, 5, 5, 9, 9, 3, 7));                           // collinear
    send_query(mk(6, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, 0, 0));         // full-range triangle
    send_query(mk(7, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_query(mk(8, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN));
    send_query(mk(9, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX));
    send_query(mk(10, 0, 0, 1, 0, 0, 1, CMAX, CMAX));                    // positive saturation
    send_query(mk(11, 0, 0, 1, 0, 0, 1, CMIN, CMAX));                    // negative saturation
    send_query(mk(12, 0, 0, 0, 1, 1, 0, CMAX, CMIN));
    send_query(mk(13, 0, 0, 3, 0, 0, 3, 1, 1));                          // inexact thirds
    send_query(mk(14, 0, 0, 3, 0, 0, 3, -1, -1));                        // negative truncation
    send_query(mk(15, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN));  // point triangle
    send_query(mk(16, 0, 0, 2, 0, 0, 2, 0, 0));
  endtask

  task automatic test_inside_stream(int count);
    repeat (count) send_query(random_inside());
  endtask

  task automatic test_mixed_stream(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)       send_query(random_inside());
      else if (pick < 8)  send_query(random_wide());
      else if (pick == 8) send_query(random_collinear());
      else                send_query(random_sliver());
    end
  endtask

  // Stop sending until the pipeline has drained completely.
  task automatic test_drain_pause();
    start_i <= 1'b0;
    while (pending_locations.size() != 0) @(posedge clk_i);
    repeat ($urandom_range(1, 5)) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_inside_stream(500);
    test_drain_pause();
    test_mixed_stream(930);
    start_i <= 1'b0;
    while (pending_locations.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Covered %0d commands, %0d results checked: %0d inside, %0d degenerate.",
             sent, checked, inside_seen, degen_seen);
    $display("Streams mixed contained queries, full-range noise, slivers and collinear sets.");
    if (mismatches == 0 && pending_locations.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
